// ----- sv/lfocal_pkg.sv -----
// Package for the LFO offset calibration sequencer.
// Types and constants shared by the stage modules; no dependencies.
package lfocal_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MV_W     = 14;
    localparam int unsigned SCALE_W  = 22;
    localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W;
    localparam int unsigned MASK_W   = 16;
    localparam int unsigned RES_OFF_W = 16;

    // round((6.144 / 32767) * 1000 * 2^24)
    localparam logic [SCALE_W-1:0] MV_SCALE = 22'd3145824;

    localparam logic [MASK_W-1:0] MASK_NONE  = 16'h0000;
    localparam logic [MASK_W-1:0] MASK_LFO0  = 16'h000F;
    localparam logic [MASK_W-1:0] MASK_LFO1  = 16'h00F0;
    localparam logic [MASK_W-1:0] MASK_FIXED = 16'h0F00;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef logic [MV_W-1:0] t_mv;

    typedef struct packed {
        logic kind;
        t_mv  mv;
    } t_item;

endpackage

// ----- sv/lfocal_if.sv -----
// Handshake channels of the LFO offset calibration sequencer.
// Command/sample channel in, result channel out; no dependencies.
interface lfocal_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] adc_sample;

    modport source (output valid, output kind, output adc_sample, input ready);
    modport sink   (input valid, input kind, input adc_sample, output ready);
endinterface

interface lfocal_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] port_mask;
    logic        start_conversion;
    logic        lfo_index;
    logic [15:0] lfo_offset;
    logic        offset_final;
    logic        calibration_done;
    logic        busy_res;

    modport source (
        output valid, output port_mask, output start_conversion, output lfo_index,
        output lfo_offset, output offset_final, output calibration_done,
        output busy_res, input ready
    );
    modport sink (
        input valid, input port_mask, input start_conversion, input lfo_index,
        input lfo_offset, input offset_final, input calibration_done,
        input busy_res, output ready
    );
endinterface

// ----- sv/lfocal_in_stage.sv -----
// Input register: takes an item and converts the ADC sample to even millivolts.
// Depends on lfocal_pkg and lfocal_in_if.
module lfocal_in_stage import lfocal_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfocal_in_if.sink    i_cmd,
    input  logic         i_advance,
    output logic         o_valid,
    output t_item        o_item
);

    logic [PROD_W-1:0] w_prod;
    logic              r_valid;
    t_item             r_item;
    t_item             n_item;

    assign w_prod       = PROD_W'(i_cmd.adc_sample) * PROD_W'(MV_SCALE);
    assign n_item.kind  = i_cmd.kind;
    assign n_item.mv    = {w_prod[PROD_W-1:PROD_W-MV_W+1], 1'b0};

    assign i_cmd.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/lfocal_seq.sv -----
// Calibration state, trim step and result register.
// Depends on lfocal_pkg and lfocal_out_if.
module lfocal_seq import lfocal_pkg::*; #(
    parameter int unsigned OFFSET_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_item         i_item,
    output logic          o_advance,
    lfocal_out_if.source  o_res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_REF  = 2'd1;
    localparam logic [1:0] PH_SEL  = 2'd2;
    localparam logic [1:0] PH_TRIM = 2'd3;

    localparam logic signed [OFFSET_WIDTH-1:0] OFF_MAX = {1'b0, {(OFFSET_WIDTH-1){1'b1}}};
    localparam logic signed [OFFSET_WIDTH-1:0] OFF_MIN = {1'b1, {(OFFSET_WIDTH-1){1'b0}}};

    logic [1:0]                     r_phase, n_phase;
    t_mv                            r_ref, n_ref;
    logic                           r_cur, n_cur;
    logic signed [OFFSET_WIDTH-1:0] r_off0, n_off0;
    logic signed [OFFSET_WIDTH-1:0] r_off1, n_off1;
    logic [MASK_W-1:0]              r_mask, n_mask;

    logic                           r_res_valid;
    logic                           r_conv, n_conv;
    logic                           r_idx, n_idx;
    logic                           r_fin, n_fin;
    logic                           r_done, n_done;
    logic [RES_OFF_W-1:0]           r_res_off, n_res_off;

    logic signed [OFFSET_WIDTH-1:0] w_cur_off, w_step_off, w_rep_off;
    logic                           w_take;

    assign o_advance = !r_res_valid || o_res.ready;
    assign w_take    = i_valid && o_advance;

    assign w_cur_off = r_cur ? r_off1 : r_off0;

    always_comb begin
        n_phase    = r_phase;
        n_ref      = r_ref;
        n_cur      = r_cur;
        n_off0     = r_off0;
        n_off1     = r_off1;
        n_mask     = r_mask;
        n_conv     = 1'b0;
        n_idx      = r_cur;
        n_fin      = 1'b0;
        n_done     = 1'b0;
        w_step_off = w_cur_off;
        if (i_item.kind == KIND_START) begin
            if (r_phase == PH_IDLE) begin
                n_off0  = '0;
                n_off1  = '0;
                n_cur   = 1'b0;
                n_mask  = MASK_FIXED;
                n_phase = PH_REF;
                n_conv  = 1'b1;
                n_idx   = 1'b0;
            end
        end else begin
            unique case (r_phase)
                PH_REF: begin
                    n_ref   = i_item.mv;
                    n_cur   = 1'b0;
                    n_mask  = MASK_LFO0;
                    n_phase = PH_TRIM;
                    n_conv  = 1'b1;
                    n_idx   = 1'b0;
                end
                PH_SEL: begin
                    n_mask  = r_cur ? MASK_LFO1 : MASK_LFO0;
                    n_phase = PH_TRIM;
                    n_conv  = 1'b1;
                end
                PH_TRIM: begin
                    if (i_item.mv < r_ref) begin
                        if (w_cur_off != OFF_MAX) begin
                            w_step_off = w_cur_off + OFFSET_WIDTH'(1);
                        end
                        n_conv = 1'b1;
                    end else if (i_item.mv > r_ref) begin
                        if (w_cur_off != OFF_MIN) begin
                            w_step_off = w_cur_off - OFFSET_WIDTH'(1);
                        end
                        n_conv = 1'b1;
                    end else if (!r_cur) begin
                        n_cur  = 1'b1;
                        n_mask = MASK_LFO1;
                        n_conv = 1'b1;
                        n_idx  = 1'b0;
                        n_fin  = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                        n_mask  = MASK_FIXED;
                        n_idx   = 1'b1;
                        n_fin   = 1'b1;
                        n_done  = 1'b1;
                    end
                    if (r_cur) begin
                        n_off1 = w_step_off;
                    end else begin
                        n_off0 = w_step_off;
                    end
                end
                default: begin
                end
            endcase
        end
        w_rep_off = n_idx ? n_off1 : n_off0;
        n_res_off = RES_OFF_W'(signed'(w_rep_off));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ref       <= '0;
            r_cur       <= 1'b0;
            r_off0      <= '0;
            r_off1      <= '0;
            r_mask      <= MASK_NONE;
            r_res_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_res_valid <= i_valid;
            end
            if (w_take) begin
                r_phase <= n_phase;
                r_ref   <= n_ref;
                r_cur   <= n_cur;
                r_off0  <= n_off0;
                r_off1  <= n_off1;
                r_mask  <= n_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_conv    <= n_conv;
            r_idx     <= n_idx;
            r_fin     <= n_fin;
            r_done    <= n_done;
            r_res_off <= n_res_off;
        end
    end

    logic [MASK_W-1:0] r_res_mask;
    logic              r_res_busy;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res_mask <= n_mask;
            r_res_busy <= (n_phase != PH_IDLE);
        end
    end

    assign o_res.valid            = r_res_valid;
    assign o_res.port_mask        = r_res_mask;
    assign o_res.start_conversion = r_conv;
    assign o_res.lfo_index        = r_idx;
    assign o_res.lfo_offset       = r_res_off;
    assign o_res.offset_final     = r_fin;
    assign o_res.calibration_done = r_done;
    assign o_res.busy_res         = r_res_busy;

endmodule

// ----- sv/lfo_offset_calibration_fsm.sv -----
// LFO offset calibration sequencer, top level.
// Takes one item per clock while the result channel is not stalled: a start
// command or an ADC sample. Each item gives exactly one result, which passes
// through the input register (with the millivolt conversion), then the trim
// step into the result register; the calibration state is updated as the
// result is registered, so the next item sees it at once. The input register
// holds one more item while a result waits; after that the input stalls until
// the result is taken.
// Depends on lfocal_pkg, lfocal_if, lfocal_in_stage and lfocal_seq.
module lfo_offset_calibration_fsm import lfocal_pkg::*; #(
    parameter int unsigned OFFSET_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfocal_in_if.sink     i_cmd,
    lfocal_out_if.source  o_res
);

    logic  w_valid;
    logic  w_advance;
    t_item w_item;

    lfocal_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_advance (w_advance),
        .o_valid   (w_valid),
        .o_item    (w_item)
    );

    lfocal_seq #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid),
        .i_item    (w_item),
        .o_advance (w_advance),
        .o_res     (o_res)
    );

endmodule
